@@ hw/rtl/rgbapm_pkg.sv @@
// Package: pixel beat types, lane type handed along the divider chain, register indexes.
package rgbapm_pkg;

	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 3;
	localparam int REM_W     = 2 * CHAN_W;
	localparam int DSH_W     = 2 * CHAN_W - 1;
	localparam int NUM_CELLS = CHAN_W;
	localparam int LATENCY   = NUM_CELLS + 2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PREMUL = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_PREMUL   = 1'b1;

	// premultiply divides by full scale with half-step rounding
	localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
	localparam logic [REM_W-1:0]  PRE_ROUND  = 16'd127;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       invalid_pixel;
	} pixel_out_t;

	typedef struct packed {
		logic src_premul;
		logic dst_premul;
	} mode_t;

	// one pixel in flight through the divider cells
	typedef struct packed {
		logic [NUM_CHAN-1:0][REM_W-1:0]  rem;
		logic [NUM_CHAN-1:0][DSH_W-1:0]  dsh;
		logic [NUM_CHAN-1:0][CHAN_W-1:0] quo;
		logic [CHAN_W-1:0]               alpha;
		logic                            invalid;
	} lane_t;

endpackage

@@ hw/rtl/rgbapm_front.sv @@
// Front end: channel products, dividend/divisor selection and invalid flag.
module rgbapm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rgbapm_pkg::pixel_in_t pix,
	input  rgbapm_pkg::mode_t   mode,
	output logic                out_valid,
	output rgbapm_pkg::lane_t   out_lane
);

	localparam int CW = rgbapm_pkg::CHAN_W;
	localparam int RW = rgbapm_pkg::REM_W;
	localparam int NC = rgbapm_pkg::NUM_CHAN;

	logic                       valid_s1;
	logic [NC-1:0][CW-1:0]      chan_s1;
	logic [NC-1:0][RW-1:0]      prod_s1;
	logic [CW-1:0]              alpha_s1;
	logic                       invalid_s1;
	rgbapm_pkg::mode_t          mode_s1;

	logic [NC-1:0][CW-1:0]      chan_in;
	logic [NC-1:0]              over;

	assign chan_in[0] = pix.red_in;
	assign chan_in[1] = pix.green_in;
	assign chan_in[2] = pix.blue_in;

	// color above alpha flags a bad premultiplied source
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			over[i] = chan_in[i] > pix.alpha_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1: c*a per channel
	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			chan_s1[i] <= chan_in[i];
			prod_s1[i] <= RW'(chan_in[i]) * RW'(pix.alpha_in);
		end
		alpha_s1   <= pix.alpha_in;
		invalid_s1 <= mode.src_premul & (|over);
		mode_s1    <= mode;
	end

	// stage 2: pick dividend and divisor for each channel
	logic [NC-1:0][RW-1:0] num_un;
	logic [NC-1:0][RW-1:0] rem_sel;
	logic [NC-1:0][CW-1:0] dvs_sel;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			// c*255 + a/2
			num_un[i] = {chan_s1[i], {CW{1'b0}}} - {{CW{1'b0}}, chan_s1[i]}
				+ {{(CW+1){1'b0}}, alpha_s1[CW-1:1]};
			if (mode_s1.src_premul == mode_s1.dst_premul) begin
				rem_sel[i] = {{CW{1'b0}}, chan_s1[i]};
				dvs_sel[i] = CW'(1);
			end else if (mode_s1.dst_premul) begin
				rem_sel[i] = prod_s1[i] + rgbapm_pkg::PRE_ROUND;
				dvs_sel[i] = rgbapm_pkg::FULL_SCALE;
			end else if (alpha_s1 == '0) begin
				rem_sel[i] = '0;
				dvs_sel[i] = CW'(1);
			end else if (num_un[i] >= {alpha_s1, {CW{1'b0}}}) begin
				// quotient would pass full scale: saturate
				rem_sel[i] = {{CW{1'b0}}, rgbapm_pkg::FULL_SCALE};
				dvs_sel[i] = CW'(1);
			end else begin
				rem_sel[i] = num_un[i];
				dvs_sel[i] = alpha_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			out_lane.rem[i] <= rem_sel[i];
			out_lane.dsh[i] <= {dvs_sel[i], {(CW-1){1'b0}}};
			out_lane.quo[i] <= '0;
		end
		out_lane.alpha   <= alpha_s1;
		out_lane.invalid <= invalid_s1;
	end

endmodule

@@ hw/rtl/rgbapm_div_cell.sv @@
// Divider cell: one restoring quotient bit for each color channel.
module rgbapm_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rgbapm_pkg::lane_t in_lane,
	output logic              out_valid,
	output rgbapm_pkg::lane_t out_lane
);

	localparam int NC = rgbapm_pkg::NUM_CHAN;
	localparam int RW = rgbapm_pkg::REM_W;
	localparam int DW = rgbapm_pkg::DSH_W;
	localparam int CW = rgbapm_pkg::CHAN_W;

	logic [NC-1:0]         ge;
	rgbapm_pkg::lane_t     nxt;

	// trial subtract of the shifted divisor, then shift it down for the next cell
	always_comb begin
		nxt = in_lane;
		for (int i = 0; i < NC; i++) begin
			ge[i]      = in_lane.rem[i] >= RW'(in_lane.dsh[i]);
			nxt.rem[i] = ge[i] ? in_lane.rem[i] - RW'(in_lane.dsh[i]) : in_lane.rem[i];
			nxt.dsh[i] = {1'b0, in_lane.dsh[i][DW-1:1]};
			nxt.quo[i] = {in_lane.quo[i][CW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_lane <= nxt;
	end

endmodule

@@ hw/rtl/rgba8_alpha_premultiply_convert.sv @@
// Top level: mode registers, front end and the row of divider cells.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+----------------------------
//  pixel in | start, busy, pixel                   | beat when start && !busy
//  result   | done, result                         | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data          | write when cfg_we
//
// One pixel accepted every cycle; busy is always low. Each result passes through two
// front-end stages (multiply, operand select) and eight divider cells, one quotient
// bit each. Reset clears the mode registers and the valid chain; nothing needs clearing
// beyond that. The receiver cannot stall.
module rgba8_alpha_premultiply_convert (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  rgbapm_pkg::pixel_in_t                  pixel,
	output logic                                   done,
	output rgbapm_pkg::pixel_out_t                 result,
	input  logic                                   cfg_we,
	input  logic [rgbapm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rgbapm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int NCELL = rgbapm_pkg::NUM_CELLS;

	rgbapm_pkg::mode_t mode_q;

	// mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbapm_pkg::REG_SOURCE_PREMUL: mode_q.src_premul <= cfg_data[0];
				rgbapm_pkg::REG_DEST_PREMUL:   mode_q.dst_premul <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic              valid_chain [NCELL+1];
	rgbapm_pkg::lane_t lane_chain  [NCELL+1];

	rgbapm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.pix       (pixel),
		.mode      (mode_q),
		.out_valid (valid_chain[0]),
		.out_lane  (lane_chain[0])
	);

	// row of divider cells, MSB quotient bit first
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		rgbapm_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_chain[k]),
			.in_lane   (lane_chain[k]),
			.out_valid (valid_chain[k+1]),
			.out_lane  (lane_chain[k+1])
		);
	end

	assign done                 = valid_chain[NCELL];
	assign result.red_out       = lane_chain[NCELL].quo[0];
	assign result.green_out     = lane_chain[NCELL].quo[1];
	assign result.blue_out      = lane_chain[NCELL].quo[2];
	assign result.alpha_out     = lane_chain[NCELL].alpha;
	assign result.invalid_pixel = lane_chain[NCELL].invalid;

endmodule

@@ hw/rtl/rgbapm_checker.sv @@
// Port checker for the converter, bound to the top level.
module rgbapm_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  rgbapm_pkg::pixel_in_t  pixel,
	input  logic                   done,
	input  rgbapm_pkg::pixel_out_t result
);

	localparam int LAT = rgbapm_pkg::LATENCY;

	// every accepted beat yields a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat gave no result");

	// no result without a beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without an accepted beat");

	// alpha travels through unchanged
	a_alpha_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT (result.alpha_out == $past(pixel.alpha_in, LAT)))
		else $error("alpha changed in flight");

	// full alpha can never be exceeded by a colour channel
	a_full_alpha_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.alpha_out == 8'hFF) |-> !result.invalid_pixel)
		else $error("invalid flag with full alpha");

endmodule

bind rgba8_alpha_premultiply_convert rgbapm_checker u_rgbapm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.result (result)
);
